// ===== rtl/count_mod_residue_subarrays_defines.svh =====
// Assertion helpers for the subarray counter.
// Both macros sample on clk and stay quiet while arst_n is low.
`ifndef COUNT_MOD_RESIDUE_SUBARRAYS_DEFINES_SVH
`define COUNT_MOD_RESIDUE_SUBARRAYS_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define CMRS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmrs assertion failed");
// next-cycle implication
`define CMRS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmrs assertion failed");
`else
`define CMRS_ASSERT_IMP(label, ante, cons)
`define CMRS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/cmrs_pkg.sv =====
package cmrs_pkg;

	localparam int RES_W    = 11;  // modulus / residue width
	localparam int WANT_W   = 10;  // wanted residue width
	localparam int VAL_W    = 30;  // element width
	localparam int TOT_W    = 40;  // running total width
	localparam int CNT_W    = 21;  // histogram count width
	localparam int EP_W     = 8;   // array epoch tag width
	localparam int DIV_BITS = 3;   // dividend bits retired per divider stage
	localparam int DIV_STG  = VAL_W / DIV_BITS;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_REDUCE
	} state_t;

	typedef enum logic {
		REG_MODULUS = 1'b0,
		REG_WANTED  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [EP_W-1:0]  tag;
		logic [CNT_W-1:0] cnt;
	} hist_word_t;

	// one restoring remainder step; r < m on entry, result < m
	function automatic logic [RES_W-1:0] mod_step(
		input logic [RES_W-1:0] r,
		input logic             b,
		input logic [RES_W-1:0] m
	);
		logic [RES_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[RES_W-1:0];
	endfunction

endpackage

// ===== rtl/cmrs_ram.sv =====
module cmrs_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/count_mod_residue_subarrays.sv =====
// Channel   Dir   Handshake            Payload
// in        in    in_valid/in_stall    element_value[29:0], array_start
// out       out   out_valid/out_stall  running_total[39:0]
// cfg       in    cfg_we               cfg_index, cfg_data[10:0]
//
// One element per cycle in steady state, unless out_stall holds a waiting result; a result passes
// the input register (loaded on the transfer edge), ten remainder stages, histogram read and update.
// Reset starts a clearing pass over all MAX_MODULUS histogram RAM addresses, with in_stall high.
// Every 255th array start after a pass waits for the pipeline to drain and runs another pass.
// A modulus write triggers a bit-serial reduction of the stored prefix residue before new input.
// out_stall with a result waiting freezes the whole pipeline, RAM reads included.
`include "count_mod_residue_subarrays_defines.svh"

module count_mod_residue_subarrays #(
	parameter int MAX_MODULUS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// element input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cmrs_pkg::VAL_W-1:0]      element_value,
	input  logic                            array_start,
	// result output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cmrs_pkg::TOT_W-1:0]      running_total,
	// configuration
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [cmrs_pkg::RES_W-1:0]      cfg_data
);

	import cmrs_pkg::*;

	localparam int AW      = $clog2(MAX_MODULUS);
	localparam int WORD_W  = $bits(hist_word_t);
	localparam int RCW     = $clog2(RES_W);
	localparam int MOD_CAP = (MAX_MODULUS > (2**RES_W - 1)) ? (2**RES_W - 1) : MAX_MODULUS;

	// ------------------------------------------------------------------
	// Configuration. The modulus register holds the clamped value, so
	// zero reads as one and anything past MAX_MODULUS as MAX_MODULUS.
	// ------------------------------------------------------------------
	logic [RES_W-1:0]  mod_q;
	logic [WANT_W-1:0] wanted_q;
	logic              mod_wr;

	assign mod_wr = cfg_we && (cfg_index == REG_MODULUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q    <= RES_W'(1);
			wanted_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MODULUS) begin
				if (cfg_data == '0) begin
					mod_q <= RES_W'(1);
				end else if (cfg_data > RES_W'(MOD_CAP)) begin
					mod_q <= RES_W'(MOD_CAP);
				end else begin
					mod_q <= cfg_data;
				end
			end else begin
				wanted_q <= cfg_data[WANT_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	state_t            state_q, state_n;
	logic              adv;          // whole pipeline moves this cycle
	logic              out_valid_q;
	logic              in_xfer;
	logic              pipe_empty;
	logic              wrap_block;   // array start with no epoch tag left
	logic [EP_W-1:0]   starts_q;     // epoch of the newest accepted item
	logic              red_pend_q;
	logic [RCW-1:0]    red_cnt_q;
	logic [RES_W-1:0]  red_rem_q;
	logic [RES_W-1:0]  red_rem_n;
	logic              red_done;
	logic [AW-1:0]     clr_addr_q;
	logic              clr_done;
	logic [RES_W-1:0]  prefix_q;     // prefix residue, reduced by current modulus
	logic [RES_W-1:0]  raw_q;        // prefix residue as left by the last element
	logic [TOT_W-1:0]  total_q;

	// divider pipeline
	logic [DIV_STG:0]  mp_valid_s;
	logic [RES_W-1:0]  mp_rem_s   [DIV_STG+1];
	logic [VAL_W-1:0]  mp_val_s   [DIV_STG+1];
	logic              mp_start_s [DIV_STG+1];
	logic [EP_W-1:0]   mp_ep_s    [DIV_STG+1];
	logic [RES_W-1:0]  mp_rem_d   [DIV_STG];

	// histogram read stage
	logic              y_valid_s1;
	logic              y_start_s1;
	logic              y_kok_s1;
	logic [EP_W-1:0]   y_ep_s1;
	logic [AW-1:0]     y_tgt_s1;
	logic [AW-1:0]     y_p_s1;

	// write forwarding: the last write lands in the same cycle as the next read
	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	hist_word_t        fwd_word_q;

	assign adv        = !out_valid_q || !out_stall;
	assign pipe_empty = (mp_valid_s == '0) && !y_valid_s1;
	assign wrap_block = in_valid && array_start && (starts_q == '1);
	assign in_stall   = (state_q != ST_RUN) || red_pend_q || !adv || wrap_block;
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign running_total = total_q;

	assign red_rem_n = mod_step(red_rem_q, raw_q[RCW'(RES_W-1) - red_cnt_q], mod_q);
	assign red_done  = (red_cnt_q == RCW'(RES_W-1));
	assign clr_done  = (clr_addr_q == AW'(MAX_MODULUS-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_done) begin
					state_n = ST_RUN;
				end
			end
			ST_RUN: begin
				priority if (red_pend_q && pipe_empty) begin
					state_n = ST_REDUCE;
				end else if (wrap_block && pipe_empty) begin
					state_n = ST_CLEAR;
				end
			end
			ST_REDUCE: begin
				if (red_done) begin
					state_n = ST_RUN;
				end
			end
			default: state_n = ST_CLEAR;
		endcase
	end

	// sweep, reduction and epoch bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			starts_q   <= EP_W'(1);
			red_pend_q <= 1'b0;
			red_cnt_q  <= '0;
			red_rem_q  <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_done ? '0 : clr_addr_q + AW'(1);
				if (clr_done) begin
					starts_q <= EP_W'(1);
				end
			end else if (in_xfer && array_start) begin
				starts_q <= starts_q + EP_W'(1);
			end

			if (mod_wr) begin
				red_pend_q <= 1'b1;
			end else if (state_q == ST_RUN && state_n == ST_REDUCE) begin
				red_pend_q <= 1'b0;
			end

			if (state_q == ST_REDUCE) begin
				red_cnt_q <= red_cnt_q + RCW'(1);
				red_rem_q <= red_rem_n;
			end else begin
				red_cnt_q <= '0;
				red_rem_q <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Remainder pipeline: element_value mod modulus, three bits a stage
	// ------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < DIV_STG; i++) begin
			mp_rem_d[i] = mp_rem_s[i];
			for (int j = 0; j < DIV_BITS; j++) begin
				mp_rem_d[i] = mod_step(mp_rem_d[i], mp_val_s[i][VAL_W-1-j], mod_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_valid_s <= '0;
		end else if (adv) begin
			mp_valid_s <= {mp_valid_s[DIV_STG-1:0], in_xfer};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mp_rem_s[0]   <= '0;
			mp_val_s[0]   <= element_value;
			mp_start_s[0] <= array_start;
			mp_ep_s[0]    <= array_start ? starts_q + EP_W'(1) : starts_q;
			for (int i = 0; i < DIV_STG; i++) begin
				mp_rem_s[i+1]   <= mp_rem_d[i];
				mp_val_s[i+1]   <= mp_val_s[i] << DIV_BITS;
				mp_start_s[i+1] <= mp_start_s[i];
				mp_ep_s[i+1]    <= mp_ep_s[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Prefix step: new prefix residue and lookup target, issue RAM reads
	// ------------------------------------------------------------------
	logic             x_valid;
	logic             x_kok;
	logic             x_match;
	logic [RES_W-1:0] x_base;
	logic [RES_W-1:0] x_inc;
	logic [RES_W-1:0] x_p;
	logic [RES_W:0]   x_sum;
	logic [RES_W-1:0] x_tgt;

	assign x_valid = mp_valid_s[DIV_STG];

	always_comb begin
		x_kok   = ({1'b0, wanted_q} < mod_q);
		x_match = x_kok && (mp_rem_s[DIV_STG] == {1'b0, wanted_q});
		x_base  = mp_start_s[DIV_STG] ? '0 : prefix_q;
		x_inc   = x_base + RES_W'(1);
		if (x_match) begin
			x_p = (x_inc == mod_q) ? '0 : x_inc;
		end else begin
			x_p = x_base;
		end
		// p + m - k lies in [1, 2m-1]: one conditional subtract
		x_sum = {1'b0, x_p} + {1'b0, mod_q} - {2'b00, wanted_q};
		if (x_sum >= {1'b0, mod_q}) begin
			x_tgt = RES_W'(x_sum - {1'b0, mod_q});
		end else begin
			x_tgt = x_sum[RES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= '0;
			raw_q      <= '0;
			y_valid_s1 <= 1'b0;
		end else begin
			if (adv) begin
				y_valid_s1 <= x_valid;
				if (x_valid) begin
					prefix_q <= x_p;
					raw_q    <= x_p;
				end
			end
			if (state_q == ST_REDUCE && red_done) begin
				prefix_q <= red_rem_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_start_s1 <= mp_start_s[DIV_STG];
			y_kok_s1   <= x_kok;
			y_ep_s1    <= mp_ep_s[DIV_STG];
			y_tgt_s1   <= AW'(x_tgt);
			y_p_s1     <= AW'(x_p);
		end
	end

	// ------------------------------------------------------------------
	// Histogram: two mirrored RAMs, one read port each (target, prefix)
	// ------------------------------------------------------------------
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	hist_word_t        ram_wword;
	logic [WORD_W-1:0] rd_tgt_raw;
	logic [WORD_W-1:0] rd_p_raw;

	cmrs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_MODULUS)
	) u_ram_tgt (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wword),
		.re    (adv),
		.raddr (AW'(x_tgt)),
		.rdata (rd_tgt_raw)
	);

	cmrs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_MODULUS)
	) u_ram_p (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wword),
		.re    (adv),
		.raddr (AW'(x_p)),
		.rdata (rd_p_raw)
	);

	// ------------------------------------------------------------------
	// Update stage: add count at target, bump count at prefix residue
	// ------------------------------------------------------------------
	hist_word_t       word_tgt;
	hist_word_t       word_p;
	logic [CNT_W-1:0] cnt_tgt;
	logic [CNT_W-1:0] cnt_p;
	logic [TOT_W-1:0] tot_base;
	logic [TOT_W:0]   tot_sum;
	logic [TOT_W-1:0] tot_new;
	hist_word_t       upd_word;

	always_comb begin
		word_tgt = hist_word_t'(rd_tgt_raw);
		word_p   = hist_word_t'(rd_p_raw);
		if (fwd_valid_q && fwd_addr_q == y_tgt_s1) begin
			word_tgt = fwd_word_q;
		end
		if (fwd_valid_q && fwd_addr_q == y_p_s1) begin
			word_p = fwd_word_q;
		end
		// entry from an older array reads as the seed: one at zero, else zero
		if (word_tgt.tag == y_ep_s1) begin
			cnt_tgt = word_tgt.cnt;
		end else begin
			cnt_tgt = (y_tgt_s1 == '0) ? CNT_W'(1) : '0;
		end
		if (word_p.tag == y_ep_s1) begin
			cnt_p = word_p.cnt;
		end else begin
			cnt_p = (y_p_s1 == '0) ? CNT_W'(1) : '0;
		end

		tot_base = y_start_s1 ? '0 : total_q;
		tot_sum  = {1'b0, tot_base} + (TOT_W+1)'(cnt_tgt);
		if (!y_kok_s1) begin
			tot_new = tot_base;
		end else if (tot_sum[TOT_W]) begin
			tot_new = '1;
		end else begin
			tot_new = tot_sum[TOT_W-1:0];
		end

		upd_word.tag = y_ep_s1;
		upd_word.cnt = (cnt_p == '1) ? cnt_p : cnt_p + CNT_W'(1);
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wword = '0;
		end else begin
			ram_we    = adv && y_valid_s1;
			ram_waddr = y_p_s1;
			ram_wword = upd_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else if (state_q == ST_CLEAR) begin
			fwd_valid_q <= 1'b0;
			// a result still waiting when the pass began leaves exactly once
			if (adv) begin
				out_valid_q <= 1'b0;
			end
		end else if (adv) begin
			fwd_valid_q <= y_valid_s1;
			out_valid_q <= y_valid_s1;
			if (y_valid_s1) begin
				total_q <= tot_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= y_p_s1;
			fwd_word_q <= upd_word;
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`CMRS_ASSERT_IMP(a_xfer_only_running, in_valid && !in_stall, state_q == ST_RUN)
	`CMRS_ASSERT_IMP(a_prefix_reduced, state_q == ST_RUN && !red_pend_q, prefix_q < mod_q)
	`CMRS_ASSERT_IMP(a_epoch_live, y_valid_s1, y_ep_s1 != '0)
	`CMRS_ASSERT_NXT(a_total_grows, y_valid_s1 && adv && !y_start_s1 && state_q == ST_RUN, running_total >= $past(total_q))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cmrs_pkg::*;

	// predictor limits, taken from the block's default sizing
	localparam int unsigned MOD_CAP     = 1024;
	localparam int unsigned VAL_MAX     = (1 << VAL_W) - 1;
	localparam int unsigned HIST_SAT    = (1 << CNT_W) - 1;
	localparam longint unsigned TOT_SAT = (64'd1 << TOT_W) - 1;

	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 153;
	localparam int HOLD_CYCLES = 250;   // long receiver hold-off, fills the pipe
	localparam int DRAIN_LIMIT = 100000;
	localparam int TAIL_CYCLES = 30;    // idle tail after the final drain

	// Prefix-residue histogram model plus the queue of totals still owed by the block.
	class subarray_tally;
		logic [RES_W-1:0]     mod_reg;
		logic [WANT_W-1:0]    want_reg;
		int unsigned          prefix;
		int unsigned          hist [MOD_CAP];
		longint unsigned      total;
		logic [TOT_W-1:0]     totals_due [$];
		int                   mismatches;

		function new();
			mod_reg    = 1;
			want_reg   = 0;
			mismatches = 0;
			reseed();
		endfunction

		function void reseed();
			foreach (hist[i])
				hist[i] = 0;
			hist[0] = 1;
			prefix  = 0;
			total   = 0;
		endfunction

		// zero acts as one, anything above the cap acts as the cap
		function int unsigned eff_modulus();
			if (mod_reg == 0)
				return 1;
			if (mod_reg > MOD_CAP)
				return MOD_CAP;
			return mod_reg;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [RES_W-1:0] val);
			if (idx == REG_MODULUS)
				mod_reg = val;
			else
				want_reg = val[WANT_W-1:0];
		endfunction

		// one accepted element: update the histogram and queue the total it produces
		function void take_element(logic [VAL_W-1:0] v, logic s);
			int unsigned     m;
			int unsigned     p;
			int unsigned     tgt;
			bit              k_ok;
			longint unsigned sum;
			m    = eff_modulus();
			k_ok = want_reg < m;
			if (s)
				reseed();
			// stored residue may predate a modulus change
			p = prefix % m;
			if (k_ok && (v % m) == want_reg)
				p = (p + 1 == m) ? 0 : p + 1;
			if (k_ok) begin
				tgt   = (p + m - want_reg) % m;
				sum   = total + hist[tgt];
				total = (sum > TOT_SAT) ? TOT_SAT : sum;
			end
			if (hist[p] < HIST_SAT)
				hist[p]++;
			prefix = p;
			totals_due.push_back(total[TOT_W-1:0]);
		endfunction

		function void check_total(logic [TOT_W-1:0] got);
			logic [TOT_W-1:0] want;
			if (totals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: running_total %0d with no transfer outstanding", $time, got);
				return;
			end
			want = totals_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: running_total expected %0d got %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return totals_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [VAL_W-1:0]    element_value;
	logic                array_start;
	logic                out_valid;
	logic                out_stall;
	logic [TOT_W-1:0]    running_total;
	logic                cfg_we;
	logic                cfg_index;
	logic [RES_W-1:0]    cfg_data;

	subarray_tally tally = new();

	// idling knobs, percent chance of starting an idle burst of randomly drawn length
	int tx_gap_pct  = 0;
	int rx_idle_pct = 0;
	bit hold_off_req = 0;

	count_mod_residue_subarrays uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.array_start   (array_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.running_total (running_total),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side: a transfer happens on a rising edge with valid high and stall low.
	// Sampling in the active region sees the pre-edge values of the block's registers.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tally.check_total(running_total);
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	// The hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall    = 1'b0;
				hold_off_req = 0;
			end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Offer one element, starting at a falling edge; returns at the falling edge
	// after the transfer. Valid stays high into the next call unless a gap is drawn.
	task automatic send_element(input logic [VAL_W-1:0] v, input logic s);
		if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid      = 1'b1;
		element_value = v;
		array_start   = s;
		do
			@(posedge clk);
		while (in_stall);
		tally.take_element(v, s);
		@(negedge clk);
	endtask

	// Stop offering and wait until every queued total has come back.
	task automatic drain();
		int n;
		n = 0;
		in_valid = 1'b0;
		while (tally.pending() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [RES_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		tally.write_reg(idx, val);
	endtask

	// Settings change only with the pipe empty.
	task automatic reconfigure(input int unsigned m, input int unsigned k);
		drain();
		write_reg(REG_MODULUS, m[RES_W-1:0]);
		write_reg(REG_WANTED, k[RES_W-1:0]);
	endtask

	// Biased element: half are built to match (when k < m), the rest are full-range, up to 4*m, or all 0s/1s.
	function automatic logic [VAL_W-1:0] pick_value(int unsigned m, int unsigned k);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50 && k < m)
			return VAL_W'(k + m * $urandom_range(0, (VAL_MAX - k) / m));
		if (r < 75)
			return VAL_W'($urandom() & VAL_MAX);
		if (r < 95)
			return VAL_W'($urandom_range(0, 4 * m));
		return r[0] ? '1 : '0;
	endfunction

	// Array length: mostly very short so array starts (and the periodic
	// clearing pass) come often, a few long ones to grow the totals.
	function automatic int pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 24);
		return $urandom_range(60, 200);
	endfunction

	// Safety net: well past the slowest legal run (gaps, stalls, clearing passes).
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned m;
		int unsigned k;
		int unsigned km;
		int          left;
		int          bad;
		logic        s;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		element_value = '0;
		array_start   = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_MODULUS;
		cfg_data      = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// ---- directed part ----
		tx_gap_pct  = 10;
		rx_idle_pct = 10;

		// reset settings: modulus one, every element matches
		send_element('0, 1'b1);
		send_element(VAL_MAX, 1'b0);
		send_element(5, 1'b0);

		// modulus zero behaves as one; same array continues
		reconfigure(0, 0);
		send_element(VAL_MAX, 1'b0);
		send_element(0, 1'b0);

		// modulus above the cap is clamped; largest wanted residue
		reconfigure(2047, 1023);
		send_element(1023, 1'b1);
		send_element(2047, 1'b0);
		send_element(0, 1'b0);

		// wanted residue not below modulus: totals repeat, histogram still moves
		reconfigure(5, 7);
		send_element(7, 1'b0);
		send_element(12, 1'b0);

		// modulus shrinks mid-array, stored prefix residue gets reduced
		reconfigure(3, 1);
		send_element(1, 1'b0);
		send_element(4, 1'b0);
		send_element(VAL_MAX, 1'b0);
		// fresh array start
		send_element(1, 1'b1);
		send_element(7, 1'b0);

		// widest legal modulus, residue zero
		reconfigure(1024, 0);
		send_element(1024, 1'b1);
		send_element(0, 1'b0);
		send_element(VAL_MAX, 1'b0);

		// ---- random phases ----
		left = 0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin m = 1;    k = 0;    end
				1: begin m = 1024; k = 1023; end
				2: begin m = 2;    k = $urandom_range(1); end
				3: begin m = 0;    k = 0;    end
				4: begin m = 2047; k = $urandom_range(1023); end
				5: begin
					// residue never reachable
					m = $urandom_range(2, 20);
					k = m + $urandom_range(0, 30);
				end
				default: begin
					case ($urandom_range(3))
						0, 1: m = $urandom_range(2, 16);
						2: m = $urandom_range(1, 1024);
						default: m = $urandom_range(1025, 2047);
					endcase
					km = (m > MOD_CAP) ? MOD_CAP : m;
					k  = ($urandom_range(9) == 0) ? $urandom_range(1023)
						: $urandom_range(0, km - 1);
				end
			endcase
			reconfigure(m, k);

			// idling mix; the tail of the run goes without any
			if (ph >= NUM_PHASES - 2) begin
				tx_gap_pct  = 0;
				rx_idle_pct = 0;
			end else begin
				case (ph % 4)
					0: begin tx_gap_pct = 0;  rx_idle_pct = 0;  end
					1: begin tx_gap_pct = 10; rx_idle_pct = 10; end
					2: begin tx_gap_pct = 30; rx_idle_pct = 5;  end
					default: begin tx_gap_pct = 5; rx_idle_pct = 30; end
				endcase
			end
			// long receiver hold-off while the sender keeps offering
			if (ph == 3) begin
				tx_gap_pct   = 0;
				hold_off_req = 1;
			end

			// half the phases keep the current array going across the modulus change
			if ($urandom_range(1))
				left = 0;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// sender pause until every result is back
				if (ph == 5 && i == 70)
					drain();
				s = (left == 0);
				if (s)
					left = pick_length();
				left--;
				send_element(pick_value(tally.eff_modulus(), tally.want_reg), s);
			end
		end

		drain();
		in_valid = 1'b0;
		repeat (TAIL_CYCLES) @(negedge clk);

		bad = tally.mismatches + tally.pending();
		if (bad == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
